### rtl/pcsb_pkg.sv
// ----------------------------------------------------------------------------
// pcsb_pkg: shared types and constants of the scan binner
// Field widths, register indexes and reset values, the queue request type
// and the arctangent table of the angle unit.
// ----------------------------------------------------------------------------
package pcsb_pkg;

	// Sizes
	localparam int BINS_DEF    = 1024;
	localparam int ADDR_MAX_W  = 12;
	localparam int COORD_W     = 20;
	localparam int RANGE_W     = 20;
	localparam int ANGLE_W     = 16;
	localparam int BIN_W       = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int QUEUE_DEPTH = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_END   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE  = 3'd7;

	// Register reset values
	localparam logic [19:0] RST_HEIGHT_LOW  = 20'h80000;
	localparam logic [19:0] RST_HEIGHT_HIGH = 20'h7FFFF;
	localparam logic [19:0] RST_RANGE_LOW   = 20'h00000;
	localparam logic [19:0] RST_RANGE_HIGH  = 20'hFFFFF;
	localparam logic [15:0] RST_ANGLE_START = 16'h8000;
	localparam logic [15:0] RST_ANGLE_END   = 16'h7FFF;
	localparam logic [15:0] RST_ANGLE_STEP  = 16'd182;
	localparam logic [19:0] RST_FILL_VALUE  = 20'hFFFFF;

	// Limits used by the front end
	typedef struct packed {
		logic signed [COORD_W-1:0] height_low;
		logic signed [COORD_W-1:0] height_high;
		logic [RANGE_W-1:0]        range_low;
		logic [RANGE_W-1:0]        range_high;
		logic signed [ANGLE_W-1:0] angle_start;
		logic signed [ANGLE_W-1:0] angle_end;
		logic [ANGLE_W-1:0]        angle_step;
	} cfg_t;

	// One request for the bin store
	typedef struct packed {
		logic                  is_read;
		logic                  in_range;
		logic [ADDR_MAX_W-1:0] addr;
		logic [BIN_W-1:0]      bin;
		logic [RANGE_W-1:0]    range;
	} op_t;

	// Arctangent of 2^-i in 1/256 binary angle units.
	function automatic logic signed [25:0] atan_entry(input logic [3:0] i);
		logic signed [25:0] v;
		unique case (i)
			4'd0:  v = 26'sd2097152;
			4'd1:  v = 26'sd1238021;
			4'd2:  v = 26'sd654136;
			4'd3:  v = 26'sd332050;
			4'd4:  v = 26'sd166669;
			4'd5:  v = 26'sd83416;
			4'd6:  v = 26'sd41718;
			4'd7:  v = 26'sd20860;
			4'd8:  v = 26'sd10430;
			4'd9:  v = 26'sd5215;
			4'd10: v = 26'sd2608;
			4'd11: v = 26'sd1304;
			4'd12: v = 26'sd652;
			4'd13: v = 26'sd326;
			4'd14: v = 26'sd163;
			4'd15: v = 26'sd81;
		endcase
		return v;
	endfunction

endpackage

### rtl/pcsb_ram.sv
// ----------------------------------------------------------------------------
// pcsb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcsb_ram #(
	parameter int WIDTH = pcsb_pkg::RANGE_W,
	parameter int DEPTH = pcsb_pkg::BINS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/pcsb_front.sv
// ----------------------------------------------------------------------------
// pcsb_front: point classifier
// Accepts items, filters points, runs the square root, CORDIC and index
// division units, and pushes store requests into the queue.
// ----------------------------------------------------------------------------
module pcsb_front #(
	parameter int BINS = pcsb_pkg::BINS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hold,
	input  pcsb_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic signed [19:0]        x_mm,
	input  logic signed [19:0]        y_mm,
	input  logic signed [19:0]        z_mm,
	input  logic                      point_valid,
	input  logic [pcsb_pkg::BIN_W-1:0] read_bin,
	output logic                      op_valid,
	input  logic                      op_ready,
	output pcsb_pkg::op_t             op
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQR   = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_ITER  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;
	localparam logic [2:0] ST_PUSH  = 3'd7;

	localparam int AW = pcsb_pkg::ADDR_MAX_W;

	logic [2:0]         state_q;
	logic [4:0]         iter_q;
	logic signed [19:0] x_q, y_q;
	logic [39:0]        sqx_q, sqy_q;
	logic [41:0]        rad_q, root_q, bit_q;
	logic signed [22:0] cx_q, cy_q;
	logic signed [25:0] cz_q;
	logic               zero_q;
	logic [16:0]        na_q, ra_q, nc_q, rc_q;
	logic [15:0]        step_q;
	logic               cnt_one_q;
	pcsb_pkg::op_t      op_q;

	logic               accept;
	logic               drop_in;

	// Square root step.
	logic [41:0] sq_sum, rad_n, root_n;
	// CORDIC step.
	logic [3:0]         sh;
	logic signed [22:0] dx, dy, cx_n, cy_n;
	logic signed [25:0] cz_n;
	// Quarter-turn setup.
	logic signed [22:0] xe, ye, cx_i, cy_i;
	logic signed [25:0] cz_i;
	logic [41:0]        rad_i;
	// Limit checks.
	logic signed [25:0] zr;
	logic signed [15:0] ang;
	logic [19:0]        rng;
	logic               drop_pt;
	logic signed [16:0] d_s, span_s;
	logic [15:0]        step_eff;
	logic               one_i;
	logic [16:0]        dn_i;
	// Divider steps.
	logic [16:0] ta, tc, ra_n, rc_n, na_n, nc_n;
	// Index.
	logic [16:0] cnt, idx;

	assign in_ready = (state_q == ST_IDLE) && !hold;
	assign accept   = in_valid && in_ready;
	assign drop_in  = !point_valid || (z_mm < cfg.height_low) || (z_mm > cfg.height_high);
	assign op_valid = (state_q == ST_PUSH);
	assign op       = op_q;

	// One step of the bitwise square root.
	always_comb begin
		sq_sum = root_q + bit_q;
		if (rad_q >= sq_sum) begin
			rad_n  = rad_q - sq_sum;
			root_n = (root_q >> 1) + bit_q;
		end else begin
			rad_n  = rad_q;
			root_n = root_q >> 1;
		end
	end

	// One CORDIC vectoring step.
	always_comb begin
		sh = iter_q[3:0];
		dx = cy_q >>> sh;
		dy = cx_q >>> sh;
		if (!cy_q[22]) begin
			cx_n = cx_q + dx;
			cy_n = cy_q - dy;
			cz_n = cz_q + pcsb_pkg::atan_entry(sh);
		end else begin
			cx_n = cx_q - dx;
			cy_n = cy_q + dy;
			cz_n = cz_q - pcsb_pkg::atan_entry(sh);
		end
	end

	// Radicand and quarter-turn of a left-half vector.
	always_comb begin
		rad_i = {2'b00, sqx_q} + {2'b00, sqy_q};
		xe    = 23'(x_q);
		ye    = 23'(y_q);
		if (x_q < 0) begin
			if (y_q >= 0) begin
				cx_i = ye;
				cy_i = -xe;
				cz_i = 26'sd4194304;
			end else begin
				cx_i = -ye;
				cy_i = xe;
				cz_i = -26'sd4194304;
			end
		end else begin
			cx_i = xe;
			cy_i = ye;
			cz_i = '0;
		end
	end

	// Rounded angle, limit checks and divider setup.
	always_comb begin
		zr       = (cz_q + 26'sd128) >>> 8;
		ang      = zero_q ? 16'sd0 : zr[15:0];
		rng      = root_q[19:0];
		drop_pt  = (rng < cfg.range_low) || (rng > cfg.range_high) ||
			(ang < cfg.angle_start) || (ang > cfg.angle_end);
		d_s      = 17'(ang) - 17'(cfg.angle_start);
		span_s   = 17'(cfg.angle_end) - 17'(cfg.angle_start);
		step_eff = (cfg.angle_step == '0) ? 16'd1 : cfg.angle_step;
		one_i    = !(cfg.angle_end > cfg.angle_start);
		dn_i     = one_i ? 17'd0 : (17'(span_s) + {1'b0, step_eff} - 17'd1);
	end

	// One restoring step of both dividers.
	always_comb begin
		ta = {ra_q[15:0], na_q[16]};
		tc = {rc_q[15:0], nc_q[16]};
		if (ta >= {1'b0, step_q}) begin
			ra_n = ta - {1'b0, step_q};
			na_n = {na_q[15:0], 1'b1};
		end else begin
			ra_n = ta;
			na_n = {na_q[15:0], 1'b0};
		end
		if (tc >= {1'b0, step_q}) begin
			rc_n = tc - {1'b0, step_q};
			nc_n = {nc_q[15:0], 1'b1};
		end else begin
			rc_n = tc;
			nc_n = {nc_q[15:0], 1'b0};
		end
	end

	// Bin count and clamped bin index.
	always_comb begin
		cnt = cnt_one_q ? 17'd1 : nc_q;
		if (cnt > 17'(BINS)) begin
			cnt = 17'(BINS);
		end
		if (cnt == '0) begin
			cnt = 17'd1;
		end
		idx = (na_q > cnt - 17'd1) ? (cnt - 17'd1) : na_q;
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command) begin
							state_q <= ST_PUSH;
						end else if (!drop_in) begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_ITER;
					iter_q  <= '0;
				end
				ST_ITER: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'd20) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					iter_q  <= '0;
					state_q <= drop_pt ? ST_IDLE : ST_DIV;
				end
				ST_DIV: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'd16) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (op_ready) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q            <= x_mm;
				y_q            <= y_mm;
				op_q.is_read   <= 1'b1;
				op_q.in_range  <= (32'(read_bin) < BINS);
				op_q.addr      <= AW'(read_bin);
				op_q.bin       <= read_bin;
				op_q.range     <= '0;
			end
			ST_SQR: begin
				sqx_q <= 40'(x_q * x_q);
				sqy_q <= 40'(y_q * y_q);
			end
			ST_PREP: begin
				rad_q  <= rad_i;
				root_q <= '0;
				bit_q  <= 42'd1 << 40;
				cx_q   <= cx_i;
				cy_q   <= cy_i;
				cz_q   <= cz_i;
				zero_q <= (x_q == '0) && (y_q == '0);
			end
			ST_ITER: begin
				rad_q  <= rad_n;
				root_q <= root_n;
				bit_q  <= bit_q >> 2;
				if (!iter_q[4]) begin
					cx_q <= cx_n;
					cy_q <= cy_n;
					cz_q <= cz_n;
				end
			end
			ST_CHECK: begin
				na_q      <= 17'(d_s);
				ra_q      <= '0;
				nc_q      <= dn_i;
				rc_q      <= '0;
				step_q    <= step_eff;
				cnt_one_q <= one_i;
			end
			ST_DIV: begin
				na_q <= na_n;
				ra_q <= ra_n;
				nc_q <= nc_n;
				rc_q <= rc_n;
			end
			ST_FIN: begin
				op_q.is_read  <= 1'b0;
				op_q.in_range <= 1'b1;
				op_q.addr     <= AW'(idx);
				op_q.bin      <= '0;
				op_q.range    <= root_q[19:0];
			end
			ST_PUSH: begin
			end
		endcase
	end

endmodule

### rtl/pcsb_queue.sv
// ----------------------------------------------------------------------------
// pcsb_queue: request queue
// Short first-in first-out buffer between the classifier and the bin store.
// ----------------------------------------------------------------------------
module pcsb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pcsb_pkg::op_t push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pcsb_pkg::op_t pop_op
);

	localparam int D  = pcsb_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);

	pcsb_pkg::op_t mem_q [D];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != (PW+1)'(D));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_op;
		end
	end

endmodule

### rtl/pcsb_back.sv
// ----------------------------------------------------------------------------
// pcsb_back: bin store
// Clears the store after reset, then carries out minimum updates and
// read-and-clear requests with a read-modify-write over the RAM.
// ----------------------------------------------------------------------------
module pcsb_back #(
	parameter int BINS = pcsb_pkg::BINS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pcsb_pkg::RANGE_W-1:0] fill_value,
	output logic                         clearing,
	input  logic                         op_valid,
	output logic                         op_ready,
	input  pcsb_pkg::op_t                op,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pcsb_pkg::BIN_W-1:0]   bin_number,
	output logic [pcsb_pkg::RANGE_W-1:0] bin_range_mm
);

	localparam int IDXW = $clog2(BINS);
	localparam int RW   = pcsb_pkg::RANGE_W;

	logic            clr_q;
	logic [IDXW-1:0] clr_cnt_q;
	logic            b_valid_s2;
	pcsb_pkg::op_t   op_s2;
	logic            out_valid_q;
	logic [pcsb_pkg::BIN_W-1:0] bin_q;
	logic [RW-1:0]   range_q;

	logic            pop, out_free, done_s2, we;
	logic [IDXW-1:0] waddr;
	logic [RW-1:0]   wdata, rdata;

	assign clearing     = clr_q;
	assign op_ready     = !clr_q && !b_valid_s2;
	assign pop          = op_valid && op_ready;
	assign out_free     = !out_valid_q || out_ready;
	assign done_s2      = b_valid_s2 && (!op_s2.is_read || out_free);
	assign out_valid    = out_valid_q;
	assign bin_number   = bin_q;
	assign bin_range_mm = range_q;

	// Write port: clearing sweep, reload on read, or new minimum.
	always_comb begin
		we    = 1'b0;
		waddr = op_s2.addr[IDXW-1:0];
		wdata = fill_value;
		if (clr_q) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '1;
		end else if (done_s2) begin
			if (op_s2.is_read) begin
				we = op_s2.in_range;
			end else begin
				we    = (op_s2.range < rdata);
				wdata = op_s2.range;
			end
		end
	end

	pcsb_ram #(
		.WIDTH (RW),
		.DEPTH (BINS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (pop),
		.raddr (op.addr[IDXW-1:0]),
		.rdata (rdata)
	);

	// Control: sweep, second stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			b_valid_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + IDXW'(1);
				if (clr_cnt_q == IDXW'(BINS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (pop) begin
				b_valid_s2 <= 1'b1;
			end else if (done_s2) begin
				b_valid_s2 <= 1'b0;
			end
			if (done_s2 && op_s2.is_read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s2 <= op;
		end
		if (done_s2 && op_s2.is_read) begin
			bin_q   <= op_s2.bin;
			range_q <= op_s2.in_range ? rdata : fill_value;
		end
	end

endmodule

### rtl/point_cloud_to_scan_binner.sv
// ----------------------------------------------------------------------------
// point_cloud_to_scan_binner: flattens 3D points into a minimum-range scan
// A classifier computes range, angle and bin of each point; a bin store
// keeps the minimum range per bin and serves read-and-clear requests.
//
//   channel   handshake            payload
//   in        in_valid/in_ready    command, x_mm, y_mm, z_mm, point_valid, read_bin
//   out       out_valid/out_ready  bin_number, bin_range_mm
//   cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A point passes through the classifier as squaring, 21 square root steps
// (the CORDIC runs alongside in the first 16), checks and 17 divider steps.
// A read goes straight from idle to push; the bin store takes a new request
// only after the last one is done. All BINS bins (1024 by default) are swept
// to all ones after reset while in_ready stays low; configuration writes are taken always.
// A stalled output holds back the bin store; the queue lets the classifier
// keep working until it fills.
// ----------------------------------------------------------------------------
module point_cloud_to_scan_binner #(
	parameter int BINS = pcsb_pkg::BINS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic signed [19:0]              x_mm,
	input  logic signed [19:0]              y_mm,
	input  logic signed [19:0]              z_mm,
	input  logic                            point_valid,
	input  logic [pcsb_pkg::BIN_W-1:0]      read_bin,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pcsb_pkg::BIN_W-1:0]      bin_number,
	output logic [pcsb_pkg::RANGE_W-1:0]    bin_range_mm,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcsb_pkg::CFG_DATA_W-1:0] cfg_data
);

	pcsb_pkg::cfg_t    cfg_q;
	logic [pcsb_pkg::RANGE_W-1:0] fill_q;
	logic              clearing;
	logic              f_valid, f_ready, b_valid, b_ready;
	pcsb_pkg::op_t     f_op, b_op;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_low  <= pcsb_pkg::RST_HEIGHT_LOW;
			cfg_q.height_high <= pcsb_pkg::RST_HEIGHT_HIGH;
			cfg_q.range_low   <= pcsb_pkg::RST_RANGE_LOW;
			cfg_q.range_high  <= pcsb_pkg::RST_RANGE_HIGH;
			cfg_q.angle_start <= pcsb_pkg::RST_ANGLE_START;
			cfg_q.angle_end   <= pcsb_pkg::RST_ANGLE_END;
			cfg_q.angle_step  <= pcsb_pkg::RST_ANGLE_STEP;
			fill_q            <= pcsb_pkg::RST_FILL_VALUE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pcsb_pkg::REG_HEIGHT_LOW:  cfg_q.height_low  <= cfg_data;
				pcsb_pkg::REG_HEIGHT_HIGH: cfg_q.height_high <= cfg_data;
				pcsb_pkg::REG_RANGE_LOW:   cfg_q.range_low   <= cfg_data;
				pcsb_pkg::REG_RANGE_HIGH:  cfg_q.range_high  <= cfg_data;
				pcsb_pkg::REG_ANGLE_START: cfg_q.angle_start <= cfg_data[15:0];
				pcsb_pkg::REG_ANGLE_END:   cfg_q.angle_end   <= cfg_data[15:0];
				pcsb_pkg::REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data[15:0];
				pcsb_pkg::REG_FILL_VALUE:  fill_q            <= cfg_data;
			endcase
		end
	end

	pcsb_front #(
		.BINS (BINS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.hold        (clearing),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.x_mm        (x_mm),
		.y_mm        (y_mm),
		.z_mm        (z_mm),
		.point_valid (point_valid),
		.read_bin    (read_bin),
		.op_valid    (f_valid),
		.op_ready    (f_ready),
		.op          (f_op)
	);

	pcsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_op     (b_op)
	);

	pcsb_back #(
		.BINS (BINS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fill_value   (fill_q),
		.clearing     (clearing),
		.op_valid     (b_valid),
		.op_ready     (b_ready),
		.op           (b_op),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bin_number   (bin_number),
		.bin_range_mm (bin_range_mm)
	);

endmodule

### tb/tb_point_cloud_to_scan_binner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_cloud_to_scan_binner: self-checking bench for the scan binner
// Drives points and bin reads with random gaps, writes the limit registers
// between phases, predicts every bin read with a local fixed-point model of
// the binner and compares each read result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_point_cloud_to_scan_binner;

	localparam int NBINS      = 1024;
	localparam int STALL_MAX  = 20000;
	localparam int DRAIN_WAIT = 200;
	localparam int BW         = pcsb_pkg::BIN_W;

	typedef enum logic {CMD_POINT = 1'b0, CMD_READ = 1'b1} cmd_e;

	typedef struct {
		logic [pcsb_pkg::BIN_W-1:0]   bin;
		logic [pcsb_pkg::RANGE_W-1:0] range;
	} scan_read_t;

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic command;
	logic signed [19:0] x_mm, y_mm, z_mm;
	logic point_valid;
	logic [pcsb_pkg::BIN_W-1:0] read_bin;
	logic out_valid, out_ready;
	logic [pcsb_pkg::BIN_W-1:0] bin_number;
	logic [pcsb_pkg::RANGE_W-1:0] bin_range_mm;
	logic cfg_valid, cfg_ready;
	logic [pcsb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pcsb_pkg::CFG_DATA_W-1:0] cfg_data;

	// Local copy of the limits and of the bin store.
	logic signed [19:0] lim_h_low, lim_h_high;
	logic [19:0] lim_r_low, lim_r_high, lim_fill;
	logic signed [15:0] lim_a_start, lim_a_end;
	logic [15:0] lim_a_step;
	logic [19:0] scan_bins [NBINS];

	scan_read_t expected_reads[$];
	int err_count = 0;
	int idle_cycles = 0;

	point_cloud_to_scan_binner u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm),
		.point_valid(point_valid), .read_bin(read_bin),
		.out_valid(out_valid), .out_ready(out_ready),
		.bin_number(bin_number), .bin_range_mm(bin_range_mm),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Arctangent steps in 1/256 binary angle units.
	function automatic longint atan_step(int i);
		longint t [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
			20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return t[i];
	endfunction

	function automatic longint planar_range(longint x, longint y);
		longint v, r, b;
		v = x * x + y * y;
		r = 0;
		b = 64'd1 << 40;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// CORDIC vectoring angle, wrapped to 16 bits.
	function automatic longint point_angle(longint x, longint y);
		longint z, t, dx, dy;
		logic signed [15:0] w;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 4194304;
			end else begin
				x = -y; y = t; z = -4194304;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		z = (z + 128) >>> 8;
		w = z[15:0];
		return longint'(w);
	endfunction

	// Applies one point to the local bin store.
	function automatic void bin_point(logic signed [19:0] x, logic signed [19:0] y,
			logic signed [19:0] z, logic pv);
		longint r, a, s, e, st, cnt, idx;
		if (!pv) return;
		if (z > lim_h_high || z < lim_h_low) return;
		r = planar_range(longint'(x), longint'(y));
		if (r < lim_r_low || r > lim_r_high) return;
		a = point_angle(longint'(x), longint'(y));
		s = longint'(lim_a_start);
		e = longint'(lim_a_end);
		if (a < s || a > e) return;
		st = (lim_a_step == '0) ? 64'sd1 : longint'(lim_a_step);
		cnt = 1;
		if (e > s) cnt = (e - s + st - 1) / st;
		if (cnt > NBINS) cnt = NBINS;
		if (cnt < 1) cnt = 1;
		idx = (a - s) / st;
		if (idx > cnt - 1) idx = cnt - 1;
		if (idx < 0) idx = 0;
		if (r < scan_bins[idx]) scan_bins[idx] = r[19:0];
	endfunction

	function automatic void read_clear_bin(logic [pcsb_pkg::BIN_W-1:0] b);
		scan_read_t rd;
		rd.bin = b;
		rd.range = scan_bins[b];
		scan_bins[b] = lim_fill;
		expected_reads.push_back(rd);
	endfunction

	// Idle time between requests: mostly the minimum, sometimes a little longer, rarely long.
	task automatic random_gap(int heavy);
		int g;
		g = 1;
		if (heavy != 0 && $urandom_range(0, 3) == 0) begin
			g = ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 60)) :
				int'($urandom_range(2, 4));
		end
		repeat (g) @(negedge clk);
	endtask

	// Sends one request on the input channel and updates the prediction.
	task automatic send_request(cmd_e c, logic signed [19:0] x, logic signed [19:0] y,
			logic signed [19:0] z, logic pv, logic [pcsb_pkg::BIN_W-1:0] rb);
		in_valid <= 1'b1;
		command <= c;
		x_mm <= x; y_mm <= y; z_mm <= z;
		point_valid <= pv;
		read_bin <= rb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == CMD_READ) read_clear_bin(rb);
		else bin_point(x, y, z, pv);
		@(negedge clk);
		in_valid <= 1'b0;
		random_gap(1);
	endtask

	task automatic send_point(logic signed [19:0] x, logic signed [19:0] y,
			logic signed [19:0] z);
		send_request(CMD_POINT, x, y, z, 1'b1, '0);
	endtask

	task automatic send_read(logic [pcsb_pkg::BIN_W-1:0] b);
		send_request(CMD_READ, 20'($urandom), 20'($urandom), 20'($urandom),
			1'($urandom_range(0, 1)), b);
	endtask

	task automatic write_reg(logic [pcsb_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pcsb_pkg::REG_HEIGHT_LOW:  lim_h_low = val;
			pcsb_pkg::REG_HEIGHT_HIGH: lim_h_high = val;
			pcsb_pkg::REG_RANGE_LOW:   lim_r_low = val;
			pcsb_pkg::REG_RANGE_HIGH:  lim_r_high = val;
			pcsb_pkg::REG_ANGLE_START: lim_a_start = val[15:0];
			pcsb_pkg::REG_ANGLE_END:   lim_a_end = val[15:0];
			pcsb_pkg::REG_ANGLE_STEP:  lim_a_step = val[15:0];
			default:                   lim_fill = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Waits for all reads to come back, then for the point pipeline to empty.
	task automatic wait_idle();
		while (expected_reads.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_limits(logic [19:0] hl, logic [19:0] hh, logic [19:0] rl,
			logic [19:0] rh, logic [15:0] as, logic [15:0] ae, logic [15:0] st,
			logic [19:0] fv);
		wait_idle();
		write_reg(pcsb_pkg::REG_HEIGHT_LOW, hl);
		write_reg(pcsb_pkg::REG_HEIGHT_HIGH, hh);
		write_reg(pcsb_pkg::REG_RANGE_LOW, rl);
		write_reg(pcsb_pkg::REG_RANGE_HIGH, rh);
		write_reg(pcsb_pkg::REG_ANGLE_START, {4'd0, as});
		write_reg(pcsb_pkg::REG_ANGLE_END, {4'd0, ae});
		write_reg(pcsb_pkg::REG_ANGLE_STEP, {4'd0, st});
		write_reg(pcsb_pkg::REG_FILL_VALUE, fv);
	endtask

	task automatic read_all_bins(int n);
		for (int i = 0; i < n; i++) send_read(i[pcsb_pkg::BIN_W-1:0]);
	endtask

	// Directed: extremes, each drop reason, axes, origin and reads of the first, middle and last bins.
	task automatic test_directed();
		send_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
		send_point(20'sh80000, 20'sh80000, 20'sh80000);
		send_point(20'sh80000, 20'sd0, 20'sd0);
		send_point(-20'sd1000, 20'sd0, 20'sd0);
		send_point(20'sd0, 20'sd0, 20'sd0);
		send_point(20'sd1000, 20'sd0, 20'sd0);
		send_point(20'sd0, 20'sd1000, 20'sd0);
		send_point(20'sd0, -20'sd1000, 20'sd0);
		send_point(-20'sd700, -20'sd1, 20'sd5);
		send_request(CMD_POINT, 20'sd50, 20'sd50, 20'sd0, 1'b0, '0);
		send_read(10'd0);
		send_read(10'd1023);
		send_read(10'd511);
		send_read(10'd512);
		set_limits(-20'sd100, 20'sd100, 20'd200, 20'd5000, -16'sd8192, 16'sd8192,
			16'd0, 20'd6000);
		send_point(20'sd1000, 20'sd10, 20'sd101);
		send_point(20'sd1000, 20'sd10, -20'sd101);
		send_point(20'sd100, 20'sd10, 20'sd0);
		send_point(20'sd6000, 20'sd10, 20'sd0);
		send_point(-20'sd1000, 20'sd10, 20'sd0);
		send_point(20'sd1000, 20'sd10, 20'sd100);
		send_point(20'sd200, 20'sd0, -20'sd100);
		send_point(20'sd5000, 20'sd0, 20'sd0);
		read_all_bins(4);
		send_read(10'd0);
		send_read(10'd1023);
	endtask

	// Random points, mostly inside the window, with reads scattered in.
	task automatic test_random(int n, int span);
		logic signed [19:0] x, y, z;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				send_read(BW'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 1023 : span)));
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
				end else begin
					x = 20'(int'($urandom_range(0, 8000)) - 4000);
					y = 20'(int'($urandom_range(0, 8000)) - 4000);
					z = 20'(int'($urandom_range(0, 400)) - 200);
				end
				send_request(CMD_POINT, x, y, z, $urandom_range(0, 9) != 0,
					BW'($urandom));
			end
		end
		read_all_bins(span + 1);
	endtask

	task automatic test_random_phases();
		set_limits(-20'sd150, 20'sd150, 20'd100, 20'd3500, 16'sh8000, 16'sd32767,
			16'd4096, 20'd3501);
		test_random(450, 16);
		set_limits(20'sh80000, 20'sd524287, 20'd0, 20'd1048575, -16'sd16384,
			16'sd16383, 16'd2048, 20'hFFFFF);
		test_random(450, 16);
		set_limits(20'sd0, 20'sd100, 20'd0, 20'd4000, 16'sd100, 16'sd100,
			16'd65535, 20'd0);
		test_random(200, 2);
		set_limits(-20'sd200, 20'sd200, 20'd50, 20'd6000, 16'sh8000, 16'sd32767,
			16'd64, 20'd55555);
		test_random(500, 255);
	endtask

	// Result checker.
	always @(posedge clk) begin
		scan_read_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reads.size() == 0) begin
				$error("unexpected read result bin %0d range %0d", bin_number, bin_range_mm);
				err_count++;
			end else begin
				e = expected_reads.pop_front();
				if (bin_number !== e.bin) begin
					$error("bin_number expected %0d actual %0d", e.bin, bin_number);
					err_count++;
				end
				if (bin_range_mm !== e.range) begin
					$error("bin_range_mm expected %0d actual %0d", e.range, bin_range_mm);
					err_count++;
				end
			end
		end
	end

	// Output stalls.
	always @(negedge clk) begin
		if ($urandom_range(0, 3) == 0)
			out_ready <= ($urandom_range(0, 20) == 0) ? 1'b0 : ~out_ready;
		else if ($urandom_range(0, 30) == 0)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	// Watchdog on cycles with no accepted request.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_MAX) begin
			$display("tb_point_cloud_to_scan_binner: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; command = 1'b0;
		x_mm = '0; y_mm = '0; z_mm = '0; point_valid = 1'b0; read_bin = '0;
		out_ready = 1'b1;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		lim_h_low = pcsb_pkg::RST_HEIGHT_LOW; lim_h_high = pcsb_pkg::RST_HEIGHT_HIGH;
		lim_r_low = pcsb_pkg::RST_RANGE_LOW; lim_r_high = pcsb_pkg::RST_RANGE_HIGH;
		lim_a_start = pcsb_pkg::RST_ANGLE_START; lim_a_end = pcsb_pkg::RST_ANGLE_END;
		lim_a_step = pcsb_pkg::RST_ANGLE_STEP; lim_fill = pcsb_pkg::RST_FILL_VALUE;
		foreach (scan_bins[i]) scan_bins[i] = 20'hFFFFF;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_phases();
		wait_idle();
		if (err_count == 0 && expected_reads.size() == 0) begin
			$display("tb_point_cloud_to_scan_binner: done, clean");
		end else begin
			$display("tb_point_cloud_to_scan_binner: done, errors");
		end
		$finish;
	end

endmodule
